// ===== hw/rtl/aapr_pkg.sv =====
// types, constants and helper functions for the axis-angle point rotator
`default_nettype none
package aapr_pkg;

	// angle reduction, degrees with 17 fraction bits
	localparam logic [25:0] ANG_PERIOD  = 26'd47185920;
	localparam logic [25:0] ANG_HALF    = 26'd23592960;
	localparam logic [25:0] ANG_QUARTER = 26'd11796480;
	// 46 periods, lifts every 32-bit angle to a positive value
	localparam logic [32:0] ANG_BIAS    = 33'd2170552320;
	// floor(2^40 / period)
	localparam logic [14:0] ANG_RECIP   = 15'd23301;
	// pi/180 in Q0.32
	localparam logic [26:0] DEG2RAD     = 27'd74961321;
	// cordic gain correction in Q2.30
	localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

	localparam int SQ_STEPS  = 31;
	localparam int DIV_STEPS = 31;

	// per-item data that travels beside the arithmetic
	typedef struct packed {
		logic            ident;
		logic [2:0][31:0] p;
		logic [2:0]      neg;
		logic            sneg;
		logic            cneg;
	} side_t;

	// truncated atan(2^-i) in Q2.30
	function automatic logic [30:0] atan_q30(input logic [4:0] idx);
		logic [30:0] a;
		case (idx)
			5'd0:  a = 31'd843314856;
			5'd1:  a = 31'd497837829;
			5'd2:  a = 31'd263043836;
			5'd3:  a = 31'd133525158;
			5'd4:  a = 31'd67021686;
			5'd5:  a = 31'd33543515;
			5'd6:  a = 31'd16775850;
			5'd7:  a = 31'd8388437;
			5'd8:  a = 31'd4194282;
			5'd9:  a = 31'd2097149;
			5'd10: a = 31'd1048575;
			5'd11: a = 31'd524287;
			5'd12: a = 31'd262143;
			5'd13: a = 31'd131071;
			5'd14: a = 31'd65535;
			5'd15: a = 31'd32767;
			5'd16: a = 31'd16383;
			5'd17: a = 31'd8191;
			5'd18: a = 31'd4095;
			5'd19: a = 31'd2047;
			5'd20: a = 31'd1023;
			5'd21: a = 31'd511;
			5'd22: a = 31'd255;
			5'd23: a = 31'd127;
			5'd24: a = 31'd63;
			5'd25: a = 31'd31;
			5'd26: a = 31'd15;
			5'd27: a = 31'd7;
			5'd28: a = 31'd3;
			5'd29: a = 31'd1;
			default: a = 31'd0;
		endcase
		return a;
	endfunction

	// shift right by 30, rounding half away from zero
	function automatic logic signed [45:0] rnd30(input logic signed [75:0] v);
		logic [75:0] t;
		t = 76'(v) + 76'd536870912 - {75'd0, v[75]};
		return $signed(t[75:30]);
	endfunction

	// clip to 32 bits; msb of the result flags saturation
	function automatic logic [32:0] clip32(input logic signed [45:0] v);
		logic [32:0] r;
		if ((v[45:31] == '0) || (v[45:31] == '1)) begin
			r = {1'b0, v[31:0]};
		end else if (v[45]) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b1, 32'h7fff_ffff};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/axis_angle_point_rotate.sv =====
// axis-angle point rotator: quaternion q*p*conj(q) as one deep pipeline
`default_nettype none
// Rotates a Q16.16 point about an axis by an angle in degrees. One item is
// taken in every cycle (busy is always low) and its result appears with a
// one-cycle done strobe; the result cannot be held off. The latency is set
// by the bit-serial square root (31 stages), the restoring divide that
// normalizes the axis (32 stages) and one CORDIC stage per iteration,
// plus 17 stages of reduction, seeds, products and rounding. An axis whose
// squared length is at or below zero_axis_epsilon << 16 passes the point
// unchanged. Write the epsilon register (cfg_we, cfg_wdata) only while no
// item is in flight.
module axis_angle_point_rotate #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic signed [31:0] angle_deg,
	input  logic signed [31:0] axis_x,
	input  logic signed [31:0] axis_y,
	input  logic signed [31:0] axis_z,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	output logic               done,
	output logic signed [31:0] rot_x,
	output logic signed [31:0] rot_y,
	output logic signed [31:0] rot_z,
	output logic               saturated
);
	import aapr_pkg::*;

	localparam int LATENCY = 80 + CORDIC_STAGES;

	logic        in_fire;
	logic [15:0] eps_q;

	assign busy    = 1'b0;
	assign in_fire = start & ~busy;

	// epsilon register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= 16'd1;
		end else if (cfg_we) begin
			eps_q <= cfg_wdata;
		end
	end

	// ---------------- front end: magnitudes, angle reduction ----------------
	logic              v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [2:0][31:0]  p_s1, p_s2, p_s3, p_s4;
	logic [2:0]        neg_s1, neg_s2, neg_s3, neg_s4;
	logic [2:0][31:0]  mag_s1, mag_s2, mag_s3;
	logic [32:0]       apos_s1, apos_s2;
	logic [2:0][63:0]  sq_s2;
	logic [31:0]       mx_s2;
	logic [47:0]       aprod_s2;
	logic              ident_s3, ident_s4;
	logic              left_s3;
	logic [4:0]        amt_s3;
	logic [26:0]       rem_s3;
	logic [2:0][29:0]  nmag_s4, nmag_s5, nmag_s6;
	logic [25:0]       ang_s4;
	side_t             side_s5, side_s6;
	logic [2:0][59:0]  nsq_s5;
	logic [23:0]       m_s5;
	logic [61:0]       ssq_s6;
	logic [50:0]       zp_s6;

	logic [2:0][31:0]  ax_in;
	logic [33:0]       apos_c;
	logic [31:0]       mx_c;
	logic [63:0]       len2_c;
	logic [4:0]        pos_c;
	logic [33:0]       qm_c, rm_c;
	logic [2:0][31:0]  sh_c;
	logic [25:0]       mm_c, mf_c;
	logic              sn_c, cn_c;
	logic [50:0]       zr_c;

	assign ax_in  = {axis_z, axis_y, axis_x};
	assign apos_c = {{2{angle_deg[31]}}, angle_deg} + {1'b0, ANG_BIAS};

	// largest axis magnitude
	always_comb begin
		mx_c = mag_s1[0];
		if (mag_s1[1] > mx_c) mx_c = mag_s1[1];
		if (mag_s1[2] > mx_c) mx_c = mag_s1[2];
	end

	// squared length, msb search, first remainder estimate
	always_comb begin
		len2_c = sq_s2[0] + sq_s2[1] + sq_s2[2];
		pos_c  = 5'd0;
		for (int b = 0; b < 32; b++) begin
			if (mx_s2[b]) pos_c = 5'(b);
		end
		qm_c = 34'(aprod_s2[47:40]) * 34'(ANG_PERIOD);
		rm_c = 34'(apos_s2) - qm_c;
	end

	// normalizing shift
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sh_c[k] = left_s3 ? (mag_s3[k] << amt_s3) : (mag_s3[k] >> amt_s3);
		end
	end

	// fold the half angle into [0, 90] degrees
	always_comb begin
		sn_c = ang_s4 >= ANG_HALF;
		mm_c = sn_c ? (ANG_PERIOD - ang_s4) : ang_s4;
		cn_c = mm_c > ANG_QUARTER;
		mf_c = cn_c ? (ANG_HALF - mm_c) : mm_c;
	end

	assign zr_c = zp_s6 + 51'd262144;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_fire;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		// s1: capture, magnitudes, biased angle
		p_s1    <= {point_z, point_y, point_x};
		apos_s1 <= apos_c[32:0];
		for (int k = 0; k < 3; k++) begin
			neg_s1[k] <= ax_in[k][31];
			mag_s1[k] <= ax_in[k][31] ? (~ax_in[k] + 32'd1) : ax_in[k];
		end
		// s2: squares, max, reciprocal product
		p_s2     <= p_s1;
		neg_s2   <= neg_s1;
		mag_s2   <= mag_s1;
		apos_s2  <= apos_s1;
		mx_s2    <= mx_c;
		aprod_s2 <= 48'(apos_s1) * 48'(ANG_RECIP);
		for (int k = 0; k < 3; k++) begin
			sq_s2[k] <= 64'(mag_s1[k]) * 64'(mag_s1[k]);
		end
		// s3: zero-axis test, shift amount, remainder
		p_s3     <= p_s2;
		neg_s3   <= neg_s2;
		mag_s3   <= mag_s2;
		ident_s3 <= len2_c <= {32'd0, eps_q, 16'd0};
		left_s3  <= pos_c < 5'd29;
		amt_s3   <= (pos_c < 5'd29) ? (5'd29 - pos_c) : (pos_c - 5'd29);
		rem_s3   <= rm_c[26:0];
		// s4: shifted magnitudes, remainder correction
		p_s4     <= p_s3;
		neg_s4   <= neg_s3;
		ident_s4 <= ident_s3;
		for (int k = 0; k < 3; k++) begin
			nmag_s4[k] <= sh_c[k][29:0];
		end
		ang_s4 <= (rem_s3 >= 27'(ANG_PERIOD)) ? 26'(rem_s3 - 27'(ANG_PERIOD))
		                                      : rem_s3[25:0];
		// s5: squares of normalized magnitudes, angle fold
		side_s5.ident <= ident_s4;
		side_s5.p     <= p_s4;
		side_s5.neg   <= neg_s4;
		side_s5.sneg  <= sn_c;
		side_s5.cneg  <= cn_c;
		nmag_s5       <= nmag_s4;
		m_s5          <= mf_c[23:0];
		for (int k = 0; k < 3; k++) begin
			nsq_s5[k] <= 60'(nmag_s4[k]) * 60'(nmag_s4[k]);
		end
		// s6: sum of squares, degrees to radians
		side_s6 <= side_s5;
		nmag_s6 <= nmag_s5;
		ssq_s6  <= 62'(nsq_s5[0]) + 62'(nsq_s5[1]) + 62'(nsq_s5[2]);
		zp_s6   <= 51'(m_s5) * 51'(DEG2RAD);
	end

	// ---------------- square root, one result bit per stage ----------------
	logic              sq_vld_s  [0:SQ_STEPS];
	logic [62:0]       sq_rem_s  [0:SQ_STEPS];
	logic [62:0]       sq_root_s [0:SQ_STEPS];
	side_t             sq_side_s [0:SQ_STEPS];
	logic signed [32:0] sq_z_s   [0:SQ_STEPS];
	logic [2:0][29:0]  sq_nmag_s [0:SQ_STEPS];

	// s7: root seed and cordic angle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_s[0] <= 1'b0;
		end else begin
			sq_vld_s[0] <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		sq_rem_s[0]  <= {1'b0, ssq_s6};
		sq_root_s[0] <= 63'd0;
		sq_side_s[0] <= side_s6;
		sq_nmag_s[0] <= nmag_s6;
		sq_z_s[0]    <= $signed({1'b0, zr_c[50:19]});
	end

	for (genvar i = 1; i <= SQ_STEPS; i++) begin : g_sqrt
		localparam logic [62:0] BIT = 63'd1 << (62 - 2 * i);
		logic [62:0] trial;
		assign trial = sq_root_s[i-1] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[i] <= 1'b0;
			end else begin
				sq_vld_s[i] <= sq_vld_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			sq_side_s[i] <= sq_side_s[i-1];
			sq_nmag_s[i] <= sq_nmag_s[i-1];
			sq_z_s[i]    <= sq_z_s[i-1];
			if (sq_rem_s[i-1] >= trial) begin
				sq_rem_s[i]  <= sq_rem_s[i-1] - trial;
				sq_root_s[i] <= (sq_root_s[i-1] >> 1) + BIT;
			end else begin
				sq_rem_s[i]  <= sq_rem_s[i-1];
				sq_root_s[i] <= sq_root_s[i-1] >> 1;
			end
		end
	end

	// ---------------- axis divide, one quotient bit per stage ----------------
	logic              dv_vld_s  [0:DIV_STEPS];
	logic [2:0][60:0]  dv_rem_s  [0:DIV_STEPS];
	logic [2:0][30:0]  dv_quo_s  [0:DIV_STEPS];
	logic [30:0]       dv_den_s  [0:DIV_STEPS];
	side_t             dv_side_s [0:DIV_STEPS];
	logic signed [32:0] dv_z_s   [0:DIV_STEPS];

	logic [30:0] root_len;
	assign root_len = sq_root_s[SQ_STEPS][30:0];

	// dividend with half the divisor added for rounding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s[0] <= 1'b0;
		end else begin
			dv_vld_s[0] <= sq_vld_s[SQ_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		dv_den_s[0]  <= root_len;
		dv_side_s[0] <= sq_side_s[SQ_STEPS];
		dv_z_s[0]    <= sq_z_s[SQ_STEPS];
		for (int k = 0; k < 3; k++) begin
			dv_rem_s[0][k] <= {1'b0, sq_nmag_s[SQ_STEPS][k], 30'd0}
			                + {31'd0, root_len[30:1]};
			dv_quo_s[0][k] <= 31'd0;
		end
	end

	for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
		localparam int B = DIV_STEPS - j;
		logic [60:0] sub;
		assign sub = 61'(dv_den_s[j-1]) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[j] <= 1'b0;
			end else begin
				dv_vld_s[j] <= dv_vld_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			dv_den_s[j]  <= dv_den_s[j-1];
			dv_side_s[j] <= dv_side_s[j-1];
			dv_z_s[j]    <= dv_z_s[j-1];
			for (int k = 0; k < 3; k++) begin
				if (dv_rem_s[j-1][k] >= sub) begin
					dv_rem_s[j][k] <= dv_rem_s[j-1][k] - sub;
					dv_quo_s[j][k] <= dv_quo_s[j-1][k] | (31'd1 << B);
				end else begin
					dv_rem_s[j][k] <= dv_rem_s[j-1][k];
					dv_quo_s[j][k] <= dv_quo_s[j-1][k];
				end
			end
		end
	end

	// ---------------- cordic, one iteration per stage ----------------
	logic              cd_vld_s  [0:CORDIC_STAGES];
	logic signed [33:0] cd_x_s   [0:CORDIC_STAGES];
	logic signed [33:0] cd_y_s   [0:CORDIC_STAGES];
	logic signed [32:0] cd_z_s   [0:CORDIC_STAGES];
	logic [2:0][31:0]  cd_u_s    [0:CORDIC_STAGES];
	side_t             cd_side_s [0:CORDIC_STAGES];

	// seed, signed unit axis
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_vld_s[0] <= 1'b0;
		end else begin
			cd_vld_s[0] <= dv_vld_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		cd_x_s[0]    <= CORDIC_K;
		cd_y_s[0]    <= 34'sd0;
		cd_z_s[0]    <= dv_z_s[DIV_STEPS];
		cd_side_s[0] <= dv_side_s[DIV_STEPS];
		for (int k = 0; k < 3; k++) begin
			cd_u_s[0][k] <= dv_side_s[DIV_STEPS].neg[k]
			              ? (32'd0 - {1'b0, dv_quo_s[DIV_STEPS][k]})
			              : {1'b0, dv_quo_s[DIV_STEPS][k]};
		end
	end

	for (genvar i = 1; i <= CORDIC_STAGES; i++) begin : g_cordic
		logic signed [33:0] dx, dy;
		logic signed [32:0] at;
		assign dx = cd_y_s[i-1] >>> (i - 1);
		assign dy = cd_x_s[i-1] >>> (i - 1);
		assign at = $signed({2'b00, atan_q30(5'(i - 1))});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cd_vld_s[i] <= 1'b0;
			end else begin
				cd_vld_s[i] <= cd_vld_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			cd_u_s[i]    <= cd_u_s[i-1];
			cd_side_s[i] <= cd_side_s[i-1];
			if (!cd_z_s[i-1][32]) begin
				cd_x_s[i] <= cd_x_s[i-1] - dx;
				cd_y_s[i] <= cd_y_s[i-1] + dy;
				cd_z_s[i] <= cd_z_s[i-1] - at;
			end else begin
				cd_x_s[i] <= cd_x_s[i-1] + dx;
				cd_y_s[i] <= cd_y_s[i-1] - dy;
				cd_z_s[i] <= cd_z_s[i-1] + at;
			end
		end
	end

	// ---------------- quaternion and the two products ----------------
	logic              v_s8, v_s9, v_s10, v_s11, v_s12, v_s13, v_s14, v_s15;
	side_t             side_s8, side_s9, side_s10, side_s11, side_s12, side_s13;
	side_t             side_s14, side_s15;
	logic signed [33:0] w_s8, sin_s8, w_s9, w_s10, w_s11, w_s12, w_s13;
	logic [2:0][31:0]  u_s8;
	logic signed [65:0] qraw_s9 [3];
	logic signed [33:0] qv_s10 [3];
	logic signed [33:0] qv_s11 [3];
	logic signed [33:0] qv_s12 [3];
	logic signed [33:0] qv_s13 [3];
	logic signed [65:0] pr_s11 [12];
	logic signed [67:0] ts_s12 [4];
	logic signed [37:0] t_s13 [4];
	logic signed [71:0] pr_s14 [12];
	logic signed [73:0] os_s15 [3];

	logic signed [45:0] qr_c [3];
	logic signed [45:0] tr_c [4];
	logic signed [45:0] or_c [3];
	logic [2:0][32:0]   cl_c;
	logic signed [31:0] pc [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			qr_c[k] = rnd30(76'(qraw_s9[k]));
			or_c[k] = rnd30(76'(os_s15[k]));
			cl_c[k] = clip32(or_c[k]);
		end
		for (int k = 0; k < 4; k++) begin
			tr_c[k] = rnd30(76'(ts_s12[k]));
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pc[k] = $signed(side_s10.p[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
			done  <= 1'b0;
		end else begin
			v_s8  <= cd_vld_s[CORDIC_STAGES];
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
			done  <= v_s15;
		end
	end

	always_ff @(posedge clk) begin
		// s8: quadrant signs on cosine and sine
		side_s8 <= cd_side_s[CORDIC_STAGES];
		u_s8    <= cd_u_s[CORDIC_STAGES];
		w_s8    <= cd_side_s[CORDIC_STAGES].cneg ? -cd_x_s[CORDIC_STAGES]
		                                         : cd_x_s[CORDIC_STAGES];
		sin_s8  <= cd_side_s[CORDIC_STAGES].sneg ? -cd_y_s[CORDIC_STAGES]
		                                         : cd_y_s[CORDIC_STAGES];
		// s9: sin times unit axis
		side_s9 <= side_s8;
		w_s9    <= w_s8;
		for (int k = 0; k < 3; k++) begin
			qraw_s9[k] <= sin_s8 * $signed(u_s8[k]);
		end
		// s10: vector part rounded to Q2.30
		side_s10 <= side_s9;
		w_s10    <= w_s9;
		for (int k = 0; k < 3; k++) begin
			qv_s10[k] <= qr_c[k][33:0];
		end
		// s11: products of q * (0, p)
		side_s11 <= side_s10;
		w_s11    <= w_s10;
		qv_s11   <= qv_s10;
		pr_s11[0]  <= qv_s10[0] * pc[0];
		pr_s11[1]  <= qv_s10[1] * pc[1];
		pr_s11[2]  <= qv_s10[2] * pc[2];
		pr_s11[3]  <= w_s10 * pc[0];
		pr_s11[4]  <= qv_s10[1] * pc[2];
		pr_s11[5]  <= qv_s10[2] * pc[1];
		pr_s11[6]  <= w_s10 * pc[1];
		pr_s11[7]  <= qv_s10[2] * pc[0];
		pr_s11[8]  <= qv_s10[0] * pc[2];
		pr_s11[9]  <= w_s10 * pc[2];
		pr_s11[10] <= qv_s10[0] * pc[1];
		pr_s11[11] <= qv_s10[1] * pc[0];
		// s12: exact sums of t
		side_s12  <= side_s11;
		w_s12     <= w_s11;
		qv_s12    <= qv_s11;
		ts_s12[0] <= -(68'(pr_s11[0]) + 68'(pr_s11[1]) + 68'(pr_s11[2]));
		ts_s12[1] <= 68'(pr_s11[3]) + 68'(pr_s11[4]) - 68'(pr_s11[5]);
		ts_s12[2] <= 68'(pr_s11[6]) + 68'(pr_s11[7]) - 68'(pr_s11[8]);
		ts_s12[3] <= 68'(pr_s11[9]) + 68'(pr_s11[10]) - 68'(pr_s11[11]);
		// s13: t rounded to Q16.16
		side_s13 <= side_s12;
		w_s13    <= w_s12;
		qv_s13   <= qv_s12;
		for (int k = 0; k < 4; k++) begin
			t_s13[k] <= tr_c[k][37:0];
		end
		// s14: products of t * conj(q)
		side_s14   <= side_s13;
		pr_s14[0]  <= w_s13 * t_s13[1];
		pr_s14[1]  <= t_s13[0] * qv_s13[0];
		pr_s14[2]  <= t_s13[2] * qv_s13[2];
		pr_s14[3]  <= t_s13[3] * qv_s13[1];
		pr_s14[4]  <= w_s13 * t_s13[2];
		pr_s14[5]  <= t_s13[0] * qv_s13[1];
		pr_s14[6]  <= t_s13[3] * qv_s13[0];
		pr_s14[7]  <= t_s13[1] * qv_s13[2];
		pr_s14[8]  <= w_s13 * t_s13[3];
		pr_s14[9]  <= t_s13[0] * qv_s13[2];
		pr_s14[10] <= t_s13[1] * qv_s13[1];
		pr_s14[11] <= t_s13[2] * qv_s13[0];
		// s15: exact sums of the vector part
		side_s15 <= side_s14;
		for (int k = 0; k < 3; k++) begin
			os_s15[k] <= 74'(pr_s14[4*k]) - 74'(pr_s14[4*k+1])
			           - 74'(pr_s14[4*k+2]) + 74'(pr_s14[4*k+3]);
		end
		// s16: round, clip, identity bypass
		if (side_s15.ident) begin
			rot_x     <= $signed(side_s15.p[0]);
			rot_y     <= $signed(side_s15.p[1]);
			rot_z     <= $signed(side_s15.p[2]);
			saturated <= 1'b0;
		end else begin
			rot_x     <= $signed(cl_c[0][31:0]);
			rot_y     <= $signed(cl_c[1][31:0]);
			rot_z     <= $signed(cl_c[2][31:0]);
			saturated <= cl_c[0][32] | cl_c[1][32] | cl_c[2][32];
		end
	end

	// ---------------- checks ----------------
	// every transfer in yields a result after the fixed latency
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> ##LATENCY done)
		else $error("result missing after accepted item");

	// no result without a transfer in at the matching cycle
	a_latency_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(in_fire, LATENCY))
		else $error("result without accepted item");

	// a saturated result has at least one component on a rail
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |->
			(rot_x == 32'sh7fff_ffff || rot_x == 32'sh8000_0000 ||
			 rot_y == 32'sh7fff_ffff || rot_y == 32'sh8000_0000 ||
			 rot_z == 32'sh7fff_ffff || rot_z == 32'sh8000_0000))
		else $error("saturation flag without clipped component");

endmodule
`default_nettype wire
